// ----- design/lps_pkg.sv -----
// Shared constants and types for the LRU page replacement stack.
// Used by lps_ctrl, lps_datapath and lru_page_replacement_stack.
package lps_pkg;

    // Default sizes
    localparam int DEF_MAX_FRAMES   = 16;
    localparam int DEF_PAGE_BITS    = 20;
    localparam int DEF_PROCESS_BITS = 8;

    // Capacity register
    localparam int         CFG_W        = 5;
    localparam logic [4:0] FRAMES_RESET = 5'd16;

    // Operation codes carried on the input tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TOUCH  = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic match;     // register the parallel tag compare
        logic exec;      // update the stack and load the result
    } t_dp_cmd;

endpackage

// ----- design/lps_datapath.sv -----
// Datapath of the LRU page replacement stack: stack cells, parallel match,
// occupancy count, capacity register and result register. Uses lps_pkg.
module lps_datapath #(
    parameter int MAX_FRAMES   = lps_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS    = lps_pkg::DEF_PAGE_BITS,
    parameter int PROCESS_BITS = lps_pkg::DEF_PROCESS_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lps_pkg::t_dp_cmd             i_cmd,
    input  logic                         i_op,
    input  logic [PAGE_BITS-1:0]         i_page,
    input  logic [PROCESS_BITS-1:0]      i_process,
    input  logic                         i_cfg_we,
    input  logic [lps_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                         o_victim_valid,
    output logic [PAGE_BITS-1:0]         o_victim_page,
    output logic [PROCESS_BITS-1:0]      o_victim_process
);
    import lps_pkg::*;

    localparam int IW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int WW = (CW > CFG_W) ? CW : CFG_W;

    // Latched word
    logic                    r_op;
    logic [PAGE_BITS-1:0]    r_pg;
    logic [PROCESS_BITS-1:0] r_pr;

    // Stack cells, top at index 0
    logic [PAGE_BITS-1:0]    r_page [MAX_FRAMES];
    logic [PROCESS_BITS-1:0] r_proc [MAX_FRAMES];

    logic [MAX_FRAMES-1:0]   r_match;
    logic [MAX_FRAMES-1:0]   n_match;
    logic [CW-1:0]           r_count;
    logic [CFG_W-1:0]        r_frames;

    logic                    r_vv;
    logic [PAGE_BITS-1:0]    r_vp;
    logic [PROCESS_BITS-1:0] r_vq;

    logic [WW-1:0]           frames_w;
    logic [WW-1:0]           max_w;
    logic [WW-1:0]           count_w;
    logic [WW-1:0]           cap_w;
    logic                    evict;
    logic [CW-1:0]           bottom_full;
    logic [IW-1:0]           bottom_idx;
    logic [MAX_FRAMES-1:0]   first_mask;
    logic                    any_match;

    // Clamp the capacity to 1..MAX_FRAMES and decide on eviction
    always_comb begin
        frames_w = WW'(r_frames);
        max_w    = WW'(MAX_FRAMES);
        count_w  = WW'(r_count);
        if (frames_w == '0) begin
            cap_w = WW'(1);
        end else if (frames_w > max_w) begin
            cap_w = max_w;
        end else begin
            cap_w = frames_w;
        end
        evict       = (count_w >= cap_w);
        bottom_full = r_count - CW'(1);
        bottom_idx  = bottom_full[IW-1:0];
    end

    // Compare every occupied cell against the latched tag
    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            n_match[k] = (CW'(k) < r_count) && (r_page[k] == r_pg) && (r_proc[k] == r_pr);
        end
    end

    // Cells from the top down to the first match, inclusive
    assign any_match  = |r_match;
    assign first_mask = r_match ^ (r_match - MAX_FRAMES'(1));

    // Hold the capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= FRAMES_RESET;
        end else if (i_cfg_we) begin
            r_frames <= i_cfg_wdata;
        end
    end

    // Latch the word and the match vector
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_op;
            r_pg <= i_page;
            r_pr <= i_process;
        end
        if (i_cmd.match) begin
            r_match <= n_match;
        end
    end

    // Shift the stack cells
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_op == OP_INSERT) begin
                r_page[0] <= r_pg;
                r_proc[0] <= r_pr;
                for (int k = 1; k < MAX_FRAMES; k++) begin
                    r_page[k] <= r_page[k-1];
                    r_proc[k] <= r_proc[k-1];
                end
            end else if (any_match) begin
                if (first_mask[0]) begin
                    r_page[0] <= r_pg;
                    r_proc[0] <= r_pr;
                end
                for (int k = 1; k < MAX_FRAMES; k++) begin
                    if (first_mask[k]) begin
                        r_page[k] <= r_page[k-1];
                        r_proc[k] <= r_proc[k-1];
                    end
                end
            end
        end
    end

    // Advance the occupancy count on a non-evicting insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec && (r_op == OP_INSERT) && !evict) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if ((r_op == OP_INSERT) && evict) begin
                r_vv <= 1'b1;
                r_vp <= r_page[bottom_idx];
                r_vq <= r_proc[bottom_idx];
            end else begin
                r_vv <= 1'b0;
                r_vp <= '0;
                r_vq <= '0;
            end
        end
    end

    assign o_victim_valid   = r_vv;
    assign o_victim_page    = r_vp;
    assign o_victim_process = r_vq;

`ifndef SYNTH
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WW'(r_count) <= WW'(MAX_FRAMES)))
        else $error("occupancy above stack depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |-> (r_count == $past(r_count) + CW'(1)))
        else $error("occupancy moved by other than one");

    a_evict_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_INSERT) && evict) |-> (r_count != '0))
        else $error("eviction from an empty stack");
`endif

endmodule

// ----- design/lps_ctrl.sv -----
// Controller of the LRU page replacement stack: sequences capture, match
// and update, and holds the stream handshakes. Uses lps_pkg.
module lps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_op,
    input  logic             i_m_tready,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    output lps_pkg::t_dp_cmd o_cmd
);
    import lps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_s_tvalid && r_ready;
    assign out_free = !r_out_valid || i_m_tready;

    // Commands to the datapath
    always_comb begin
        o_cmd.capture = accept;
        o_cmd.match   = (r_state == S_MATCH);
        o_cmd.exec    = (r_state == S_EXEC) && out_free;
    end

    // Next state and result valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_s_op == OP_TOUCH) ? S_MATCH : S_EXEC;
                end
            end
            S_MATCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered handshakes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ready     <= (n_state == S_IDLE);
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = r_ready;
    assign o_m_tvalid = r_out_valid;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

    a_match_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MATCH) |=> (r_state == S_EXEC))
        else $error("match step not followed by update");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> ($past(r_state) == S_EXEC))
        else $error("result raised outside update step");
`endif

endmodule

// ----- design/lru_page_replacement_stack.sv -----
// LRU page replacement stack, top level. Accepts one reference word at a
// time and returns one result word for each. An insert passes capture and
// stack update, a touch capture, registered parallel tag match and stack
// update; the update step loads the result register. The controller takes
// the next word in the cycle after the result register is loaded, so no
// new word is taken while the last one is in flight. A stalled output holds
// the update step until the result register can take the new word. The
// stack is a row of shifting cells, top at slot 0; its contents are
// undefined until written, only the occupancy count is cleared by reset.
// The capacity register may be written at any idle time and takes effect
// on the next word; values 0 and above MAX_FRAMES act as 1 and MAX_FRAMES.
// Depends on lps_pkg, lps_ctrl and lps_datapath.
module lru_page_replacement_stack #(
    parameter int MAX_FRAMES   = lps_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS    = lps_pkg::DEF_PAGE_BITS,
    parameter int PROCESS_BITS = lps_pkg::DEF_PROCESS_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // Capacity register write
    input  logic                                          i_cfg_we,
    input  logic [lps_pkg::CFG_W-1:0]                     i_cfg_wdata,
    // Input stream
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    // tdata from bit 0: page, process_id, zero pad
    input  logic [((PAGE_BITS+PROCESS_BITS+7)/8)*8-1:0]   i_s_tdata,
    // tuser: op
    input  logic                                          i_s_tuser,
    // Output stream
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    // tdata from bit 0: victim_page, victim_process, zero pad
    output logic [((PAGE_BITS+PROCESS_BITS+7)/8)*8-1:0]   o_m_tdata,
    // tuser: victim_valid
    output logic                                          o_m_tuser
);
    import lps_pkg::*;

    localparam int DW = ((PAGE_BITS + PROCESS_BITS + 7) / 8) * 8;

    t_dp_cmd                 cmd;
    logic [PAGE_BITS-1:0]    victim_page;
    logic [PROCESS_BITS-1:0] victim_process;

    lps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_op     (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    lps_datapath #(
        .MAX_FRAMES   (MAX_FRAMES),
        .PAGE_BITS    (PAGE_BITS),
        .PROCESS_BITS (PROCESS_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_op             (i_s_tuser),
        .i_page           (i_s_tdata[PAGE_BITS-1:0]),
        .i_process        (i_s_tdata[PAGE_BITS+PROCESS_BITS-1:PAGE_BITS]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_victim_valid   (o_m_tuser),
        .o_victim_page    (victim_page),
        .o_victim_process (victim_process)
    );

    // Pack the result word
    assign o_m_tdata = DW'({victim_process, victim_page});

endmodule
